// File: src/pkst_pkg.sv
// ---------------------------------------------------------------------------
// Port knock sequence tracker package
// Types and constants shared by the tracker core and its slot table.
// ---------------------------------------------------------------------------
package pkst_pkg;

   // Outcome codes carried in each result word.
   typedef enum logic [2:0] {
      OUT_STARTED  = 3'd0,
      OUT_ADVANCED = 3'd1,
      OUT_EVICTED  = 3'd2,
      OUT_IGNORED  = 3'd3,
      OUT_ADMITTED = 3'd4,
      OUT_REJECTED = 3'd5,
      OUT_FULL     = 3'd6
   } outcome_type;

   // Fixed field widths.
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned POS_W   = 3;
   localparam int unsigned LEN_W   = 4;

   // Length register reset value and the shortest sequence allowed.
   localparam logic [LEN_W-1:0] LEN_RESET = 4'd3;
   localparam logic [LEN_W-1:0] LEN_MIN   = 4'd2;

   // Stage given to a client on its first knock.
   localparam logic [POS_W-1:0] STAGE_FIRST = 3'd1;

   // One row of the slot table.
   typedef struct packed {
      logic [POS_W-1:0]  stage;
      logic [ADDR_W-1:0] address;
   } slot_entry_type;

   // Update command from the sequencer to the slot table.
   typedef struct packed {
      logic write;
      logic set_valid;
      logic clear_valid;
   } table_cmd_type;

endpackage

// File: src/pkst_if.sv
// ---------------------------------------------------------------------------
// Port knock sequence tracker channels
// Valid/ready channels for knock request words and result words.
// ---------------------------------------------------------------------------
interface pkst_req_if
   import pkst_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] client_address;
   logic [POS_W-1:0]  knock_position;

   modport source (output valid, output client_address, output knock_position, input ready);
   modport sink   (input valid, input client_address, input knock_position, output ready);
endinterface

interface pkst_rsp_if
   import pkst_pkg::*;
();
   logic        valid;
   logic        ready;
   logic        admit;
   outcome_type outcome;

   modport source (output valid, output admit, output outcome, input ready);
   modport sink   (input valid, input admit, input outcome, output ready);
endinterface

// File: src/pkst_slot_table.sv
// ---------------------------------------------------------------------------
// Port knock slot table
// Client address and stage memory with one registered read port, one write
// port and a valid flip-flop per slot that reset clears at once.
// ---------------------------------------------------------------------------
module pkst_slot_table
   import pkst_pkg::*;
#(
   parameter int unsigned TABLE_SLOTS = 16,
   parameter int unsigned IDX_W       = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [IDX_W-1:0]       rd_idx,
   output slot_entry_type         rd_entry,
   input  table_cmd_type          cmd,
   input  logic [IDX_W-1:0]       wr_idx,
   input  slot_entry_type         wr_entry,
   output logic [TABLE_SLOTS-1:0] valid
);

   slot_entry_type           mem [TABLE_SLOTS];
   slot_entry_type           rd_entry_ff;
   logic [TABLE_SLOTS-1:0]   valid_ff;
   logic [TABLE_SLOTS-1:0]   valid_in;

   // Registered read of the row under scan.
   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[rd_idx];
   end

   // Row write from the sequencer.
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[wr_idx] <= wr_entry;
      end
   end

   // Valid bits mark the rows that hold a live client.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.set_valid) begin
         valid_in[wr_idx] = 1'b1;
      end else if (cmd.clear_valid) begin
         valid_in[wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign valid    = valid_ff;

   // A slot is never set and cleared by the same command.
   a_set_clear_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.set_valid && cmd.clear_valid))
      else $error("slot table: set and clear in one command");

   // Marking a slot live always comes with a row write.
   a_set_writes: assert property (@(posedge clock) disable iff (reset)
      cmd.set_valid |-> cmd.write)
      else $error("slot table: slot made valid without a row write");

   // A set slot reads as live on the next cycle.
   a_set_lands: assert property (@(posedge clock) disable iff (reset)
      cmd.set_valid |=> valid_ff[$past(wr_idx)])
      else $error("slot table: valid bit not set after insert");

endmodule

// File: src/port_knock_sequence_tracker_core.sv
// Scan: a request word accepted in idle is compared with the table rows in order,
// from slot 0, stopping at a match or after the last of the TABLE_SLOTS rows.
// Flow: a new word is taken only in idle, after the last word's result is loaded,
// since the single address comparator visits one table row at a time (read, compare).
// Reset: all slots become free at once, the sequence length returns to 3, and no
// clearing pass is needed; the block is ready as soon as reset drops.
// ---------------------------------------------------------------------------
// Port knock sequence tracker core
// Tracks each client's progress through a port knock sequence with a slot
// table that a small sequencer scans one row at a time.
// ---------------------------------------------------------------------------
module port_knock_sequence_tracker_core
   import pkst_pkg::*;
#(
   parameter int unsigned TABLE_SLOTS  = 16,
   parameter int unsigned MAX_SEQUENCE = 8
) (
   input  logic             clock,
   input  logic             reset,
   pkst_req_if.sink         req_if,
   pkst_rsp_if.source       rsp_if,
   input  logic             csr_write_enable,
   input  logic [LEN_W-1:0] csr_write_data
);

   localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_SEQUENCE);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_READ    = 4'b0010,
      S_COMPARE = 4'b0100,
      S_DECIDE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  seq_len_ff;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              match_found_ff, match_found_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic [POS_W-1:0]  match_stage_ff, match_stage_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_admit_ff, rsp_admit_in;
   outcome_type       rsp_outcome_ff, rsp_outcome_in;

   slot_entry_type         rd_entry;
   slot_entry_type         wr_entry;
   logic [IDX_W-1:0]       wr_idx;
   table_cmd_type          cmd;
   logic [TABLE_SLOTS-1:0] valid;

   logic             req_accept;
   logic             out_free;
   logic             row_hit;
   logic [POS_W-1:0] last_pos;
   outcome_type      outcome;

   pkst_slot_table #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (scan_idx_ff),
      .rd_entry (rd_entry),
      .cmd      (cmd),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry),
      .valid    (valid)
   );

   // Sequence length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= LEN_RESET;
      end else if (csr_write_enable) begin
         seq_len_ff <= csr_write_data;
      end
   end

   // Effective length is clamped into the supported range at accept time.
   always_comb begin
      if (seq_len_ff < LEN_MIN) begin
         len_in = LEN_MIN;
      end else if (seq_len_ff > LEN_MAX) begin
         len_in = LEN_MAX;
      end else begin
         len_in = seq_len_ff;
      end
   end

   assign req_accept = req_if.valid && req_if.ready;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign row_hit    = valid[scan_idx_ff] && (rd_entry.address == addr_ff);
   assign last_pos   = POS_W'(len_ff - 4'd1);

   // Request word capture.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         addr_ff <= req_if.client_address;
         pos_ff  <= req_if.knock_position;
         len_ff  <= len_in;
      end
   end

   // Sequencer: scan rows until a match or the end, then decide and update.
   always_comb begin
      state_in       = state_ff;
      scan_idx_in    = scan_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_stage_in = match_stage_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in       = S_READ;
               scan_idx_in    = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
            end
         end
         S_READ: begin
            state_in = S_COMPARE;
         end
         S_COMPARE: begin
            if (!valid[scan_idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = scan_idx_ff;
            end
            if (row_hit) begin
               match_found_in = 1'b1;
               match_idx_in   = scan_idx_ff;
               match_stage_in = rd_entry.stage;
               state_in       = S_DECIDE;
            end else if (scan_idx_ff == LAST_IDX) begin
               state_in = S_DECIDE;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
               state_in    = S_READ;
            end
         end
         S_DECIDE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outcome and table update for the word under decision.
   always_comb begin
      cmd              = '0;
      wr_idx           = match_idx_ff;
      wr_entry.address = addr_ff;
      wr_entry.stage   = STAGE_FIRST;
      if ({1'b0, pos_ff} >= len_ff) begin
         outcome = OUT_IGNORED;
      end else if (pos_ff == '0) begin
         if (match_found_ff || free_found_ff) begin
            outcome       = OUT_STARTED;
            cmd.write     = 1'b1;
            cmd.set_valid = 1'b1;
            wr_idx        = match_found_ff ? match_idx_ff : free_idx_ff;
         end else begin
            outcome = OUT_FULL;
         end
      end else if (!match_found_ff) begin
         outcome = OUT_IGNORED;
      end else if (pos_ff == last_pos) begin
         outcome         = (match_stage_ff == last_pos) ? OUT_ADMITTED : OUT_REJECTED;
         cmd.clear_valid = 1'b1;
      end else if (match_stage_ff == pos_ff) begin
         outcome        = OUT_ADVANCED;
         cmd.write      = 1'b1;
         wr_entry.stage = pos_ff + POS_W'(1);
      end else begin
         outcome         = OUT_EVICTED;
         cmd.clear_valid = 1'b1;
      end
      if (!(state_ff == S_DECIDE && out_free)) begin
         cmd = '0;
      end
   end

   // Result word register, loaded as the decision completes.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_admit_in   = rsp_admit_ff;
      rsp_outcome_in = rsp_outcome_ff;
      if (state_ff == S_DECIDE && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_admit_in   = (outcome == OUT_ADMITTED);
         rsp_outcome_in = outcome;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff    <= scan_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_stage_ff <= match_stage_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      rsp_admit_ff   <= rsp_admit_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   assign req_if.ready   = (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.admit   = rsp_admit_ff;
   assign rsp_if.outcome = rsp_outcome_ff;

   // An accepted word always starts a table scan.
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_READ)
      else $error("tracker: accepted word did not start a scan");

   // The scan never leaves the table.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMPARE |-> scan_idx_ff <= LAST_IDX)
      else $error("tracker: scan index beyond table");

   // An insert only targets a matched or a free slot.
   a_insert_target: assert property (@(posedge clock) disable iff (reset)
      cmd.set_valid |-> (match_found_ff || free_found_ff))
      else $error("tracker: insert without a target slot");

   // Admit is raised exactly for the admitted outcome.
   a_admit_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_admit_ff == (rsp_outcome_ff == OUT_ADMITTED)))
      else $error("tracker: admit flag disagrees with outcome");

endmodule
